FILE: design/dpg_pkg.sv
// ----------------------------------------------------------------------------
// dpg_pkg
// Shared types and constants for the depth pixel to grid cell projector.
// ----------------------------------------------------------------------------
package dpg_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int GRID_BITS  = 12;

  localparam int DEPTH_W  = 16;
  localparam int CENTRE_W = 16;
  localparam int INVF_W   = 24;
  localparam int SCALE_W  = 24;
  localparam int HALF_W   = 11;
  localparam int FLOOR_W  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // offset from principal point, Q.4
  localparam int P4_W = PIXEL_BITS + 4;
  localparam int DU_W = (P4_W > CENTRE_W) ? P4_W : CENTRE_W;
  // ray slope, Q16
  localparam int RX_W = DU_W + INVF_W - 12;
  // depth in cells, Q16
  localparam int Z_W  = DEPTH_W + SCALE_W;
  localparam int ZC_W = 28;
  localparam logic [ZC_W-1:0] ZCAP = ZC_W'(1) << (ZC_W - 1);
  // offset magnitude, Q16
  localparam int MAG_W = RX_W + ZC_W - 16;
  // integer part arithmetic on cell indices
  localparam int CALC_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CX          = 3'd0,
    CFG_CY          = 3'd1,
    CFG_INV_FX      = 3'd2,
    CFG_INV_FY      = 3'd3,
    CFG_CELL_SCALE  = 3'd4,
    CFG_HALF_ROWS   = 3'd5,
    CFG_HALF_COLS   = 3'd6,
    CFG_FLOOR_LIMIT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CENTRE_W-1:0]       cx_q4;
    logic [CENTRE_W-1:0]       cy_q4;
    logic [INVF_W-1:0]         inv_fx_q24;
    logic [INVF_W-1:0]         inv_fy_q24;
    logic [SCALE_W-1:0]        cell_scale_q16;
    logic [HALF_W-1:0]         half_rows;
    logic [HALF_W-1:0]         half_cols;
    logic signed [FLOOR_W-1:0] floor_limit_q4;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;
    logic [DEPTH_W-1:0]    depth_raw;
  } pixel_t;

  typedef struct packed {
    logic                 cell_valid;
    logic [GRID_BITS-1:0] cell_row;
    logic [GRID_BITS-1:0] cell_col;
  } cell_t;

  // load enables of the first three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

FILE: design/depth_pixel_to_grid_cell.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_grid_cell
// Back-projects a depth pixel through a pinhole model onto a 2-D obstacle grid.
// Pipeline: three multiply stages, then the bound checks into the output register.
// Throughput: one transaction per cycle while out_ready_i holds; each stage stalls only when full.
// Reset: pipeline emptied, configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module depth_pixel_to_grid_cell import dpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pixel_t                in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cell_t                 out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  stage_en_t en;
  logic      en4;
  logic      v1_q, v2_q, v3_q, v4_q;

  logic [Z_W-1:0]    z_d, z1_q;
  logic              dnz1_q, dnz2_q, dnz3_q;
  logic [ZC_W-1:0]   zc_d, zc2_q;
  logic              zok_d, zok2_q, zok3_q;
  logic [CALC_W-1:0] zi2_q, zi3_q;

  logic [MAG_W-1:0] xmag, ymag;
  logic             xneg, yneg;

  logic                    xok, yok, ok;
  logic signed [MAG_W:0]   ys, fl_ext;
  logic [MAG_W:0]          xceil;
  logic [CALC_W-1:0]       row_w, col_w;
  cell_t                   res_d, res_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cx_q4          <= CENTRE_W'(5120);
      cfg_q.cy_q4          <= CENTRE_W'(3840);
      cfg_q.inv_fx_q24     <= INVF_W'(31957);
      cfg_q.inv_fy_q24     <= INVF_W'(31957);
      cfg_q.cell_scale_q16 <= SCALE_W'(1311);
      cfg_q.half_rows      <= HALF_W'(100);
      cfg_q.half_cols      <= HALF_W'(100);
      cfg_q.floor_limit_q4 <= -FLOOR_W'(272);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CX:          cfg_q.cx_q4          <= cfg_data_i[CENTRE_W-1:0];
        CFG_CY:          cfg_q.cy_q4          <= cfg_data_i[CENTRE_W-1:0];
        CFG_INV_FX:      cfg_q.inv_fx_q24     <= cfg_data_i[INVF_W-1:0];
        CFG_INV_FY:      cfg_q.inv_fy_q24     <= cfg_data_i[INVF_W-1:0];
        CFG_CELL_SCALE:  cfg_q.cell_scale_q16 <= cfg_data_i[SCALE_W-1:0];
        CFG_HALF_ROWS:   cfg_q.half_rows      <= cfg_data_i[HALF_W-1:0];
        CFG_HALF_COLS:   cfg_q.half_cols      <= cfg_data_i[HALF_W-1:0];
        CFG_FLOOR_LIMIT: cfg_q.floor_limit_q4 <= cfg_data_i[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign en4    = !v4_q || out_ready_i;
  assign en.s3  = !v3_q || en4;
  assign en.s2  = !v2_q || en.s3;
  assign en.s1  = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en4)   v4_q <= v3_q;
    end
  end

  // depth path
  always_comb begin
    z_d   = Z_W'(in_data_i.depth_raw) * Z_W'(cfg_q.cell_scale_q16);
    zc_d  = (z1_q < Z_W'(ZCAP)) ? z1_q[ZC_W-1:0] : ZCAP;
    zok_d = z1_q < Z_W'({cfg_q.half_cols, 16'h0000});
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      z1_q   <= z_d;
      dnz1_q <= (in_data_i.depth_raw != '0);
    end
    if (en.s2) begin
      zc2_q  <= zc_d;
      zok2_q <= zok_d;
      zi2_q  <= z1_q[16 +: CALC_W];
      dnz2_q <= dnz1_q;
    end
    if (en.s3) begin
      zok3_q <= zok2_q;
      zi3_q  <= zi2_q;
      dnz3_q <= dnz2_q;
    end
  end

  dpg_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .pix_i    (in_data_i.pixel_col),
    .centre_i (cfg_q.cx_q4),
    .inv_f_i  (cfg_q.inv_fx_q24),
    .zc_i     (zc2_q),
    .mag_o    (xmag),
    .neg_o    (xneg)
  );

  dpg_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .pix_i    (in_data_i.pixel_row),
    .centre_i (cfg_q.cy_q4),
    .inv_f_i  (cfg_q.inv_fy_q24),
    .zc_i     (zc2_q),
    .mag_o    (ymag),
    .neg_o    (yneg)
  );

  // bound checks and cell indices
  always_comb begin
    xok    = xmag < MAG_W'({cfg_q.half_rows, 16'h0000});
    ys     = yneg ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
    fl_ext = $signed({{(MAG_W + 1 - FLOOR_W - 12){cfg_q.floor_limit_q4[FLOOR_W-1]}},
                      cfg_q.floor_limit_q4, 12'h000});
    yok    = ys > fl_ext;
    ok     = dnz3_q && xok && zok3_q && yok;
    xceil  = {1'b0, xmag} + (MAG_W + 1)'(16'hFFFF);
    if (xneg) begin
      row_w = CALC_W'(cfg_q.half_rows) - xceil[16 +: CALC_W];
    end else begin
      row_w = CALC_W'(cfg_q.half_rows) + xmag[16 +: CALC_W];
    end
    col_w = zi3_q + CALC_W'(cfg_q.half_cols);
    res_d.cell_valid = ok;
    res_d.cell_row   = ok ? row_w[GRID_BITS-1:0] : '0;
    res_d.cell_col   = ok ? col_w[GRID_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = res_q;

endmodule

FILE: design/dpg_axis.sv
// ----------------------------------------------------------------------------
// dpg_axis
// Three-stage offset magnitude for one image axis: |p*16 - c| * inv_f * depth.
// ----------------------------------------------------------------------------
module dpg_axis import dpg_pkg::*; (
  input  logic                  clk_i,
  input  stage_en_t             en_i,
  input  logic [PIXEL_BITS-1:0] pix_i,
  input  logic [CENTRE_W-1:0]   centre_i,
  input  logic [INVF_W-1:0]     inv_f_i,
  input  logic [ZC_W-1:0]       zc_i,
  output logic [MAG_W-1:0]      mag_o,
  output logic                  neg_o
);

  logic [DU_W-1:0]  p4_ext, c_ext, du_d, du_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [RX_W-1:0]  rx_d, rx_q;
  logic [MAG_W-1:0] mag_d, mag_q;

  logic [DU_W+INVF_W-1:0] rprod;
  logic [RX_W+ZC_W-1:0]   mprod;

  always_comb begin
    p4_ext = DU_W'({pix_i, 4'b0000});
    c_ext  = DU_W'(centre_i);
    if (p4_ext < c_ext) begin
      du_d = c_ext - p4_ext;
    end else begin
      du_d = p4_ext - c_ext;
    end
    rprod = (DU_W + INVF_W)'(du_q) * (DU_W + INVF_W)'(inv_f_i);
    rx_d  = rprod[12 +: RX_W];
    mprod = (RX_W + ZC_W)'(rx_q) * (RX_W + ZC_W)'(zc_i);
    mag_d = mprod[16 +: MAG_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      du_q   <= du_d;
      neg1_q <= (p4_ext < c_ext);
    end
    if (en_i.s2) begin
      rx_q   <= rx_d;
      neg2_q <= neg1_q;
    end
    if (en_i.s3) begin
      mag_q  <= mag_d;
      neg3_q <= neg2_q;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg3_q;

endmodule

FILE: test/grid_cell_checker.sv
// ----------------------------------------------------------------------------
// grid_cell_checker
// Watches the pixel, cell and register channels of depth_pixel_to_grid_cell.
// Projects every accepted pixel onto the grid with its own copy of the camera
// and grid registers. Compares each cell transaction field by field with the
// oldest projection still waiting.
// ----------------------------------------------------------------------------
module grid_cell_checker import dpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  pixel_t                in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  cell_t                 out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o = 0,
  output int                    pending_o = 0
);

  localparam logic [63:0] DEPTH_CAP = 64'd1 << 27;

  cfg_t  cam;
  cell_t expected_cells [$];
  cell_t want;

  function automatic logic [63:0] ray_offset(input logic [PIXEL_BITS-1:0] pix,
                                             input logic [CENTRE_W-1:0] centre,
                                             input logic [INVF_W-1:0] inv_f,
                                             input logic [63:0] zc,
                                             output logic neg);
    logic [63:0] p4, du, slope;
    p4 = 64'(pix) << 4;
    neg = p4 < 64'(centre);
    du = neg ? 64'(centre) - p4 : p4 - 64'(centre);
    slope = (du * 64'(inv_f)) >> 12;
    return (slope * zc) >> 16;
  endfunction

  function automatic cell_t project_pixel(input pixel_t p);
    logic [63:0] z, zc, xmag, ymag, row, col;
    logic        xneg, yneg, hit;
    longint      ys, floor_q16;
    cell_t       c;
    z = 64'(p.depth_raw) * 64'(cam.cell_scale_q16);
    zc = (z < DEPTH_CAP) ? z : DEPTH_CAP;
    xmag = ray_offset(p.pixel_col, cam.cx_q4, cam.inv_fx_q24, zc, xneg);
    ymag = ray_offset(p.pixel_row, cam.cy_q4, cam.inv_fy_q24, zc, yneg);
    ys = yneg ? -longint'(ymag) : longint'(ymag);
    floor_q16 = longint'($signed(cam.floor_limit_q4)) * 4096;
    hit = (p.depth_raw != 0) && (xmag < (64'(cam.half_rows) << 16))
          && (z < (64'(cam.half_cols) << 16)) && (ys > floor_q16);
    row = '0;
    col = '0;
    if (hit) begin
      // negative offsets floor away from zero
      row = xneg ? 64'(cam.half_rows) - ((xmag + 64'hFFFF) >> 16)
                 : 64'(cam.half_rows) + (xmag >> 16);
      col = (z >> 16) + 64'(cam.half_cols);
    end
    c.cell_valid = hit;
    c.cell_row = row[GRID_BITS-1:0];
    c.cell_col = col[GRID_BITS-1:0];
    return c;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam.cx_q4 = 16'd5120;
      cam.cy_q4 = 16'd3840;
      cam.inv_fx_q24 = 24'd31957;
      cam.inv_fy_q24 = 24'd31957;
      cam.cell_scale_q16 = 24'd1311;
      cam.half_rows = 11'd100;
      cam.half_cols = 11'd100;
      cam.floor_limit_q4 = -16'sd272;
      expected_cells.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CX:          cam.cx_q4 = cfg_data_i[CENTRE_W-1:0];
          CFG_CY:          cam.cy_q4 = cfg_data_i[CENTRE_W-1:0];
          CFG_INV_FX:      cam.inv_fx_q24 = cfg_data_i[INVF_W-1:0];
          CFG_INV_FY:      cam.inv_fy_q24 = cfg_data_i[INVF_W-1:0];
          CFG_CELL_SCALE:  cam.cell_scale_q16 = cfg_data_i[SCALE_W-1:0];
          CFG_HALF_ROWS:   cam.half_rows = cfg_data_i[HALF_W-1:0];
          CFG_HALF_COLS:   cam.half_cols = cfg_data_i[HALF_W-1:0];
          CFG_FLOOR_LIMIT: cam.floor_limit_q4 = cfg_data_i[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_cells.push_back(project_pixel(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_cells.size() == 0) begin
          $error("cell transaction with none expected: valid %0d row %0d col %0d",
                 out_data_i.cell_valid, out_data_i.cell_row, out_data_i.cell_col);
          errors_o++;
        end else begin
          want = expected_cells.pop_front();
          compare_field("cell_valid", 16'(want.cell_valid), 16'(out_data_i.cell_valid));
          compare_field("cell_row", 16'(want.cell_row), 16'(out_data_i.cell_row));
          compare_field("cell_col", 16'(want.cell_col), 16'(out_data_i.cell_col));
        end
      end
    end
    pending_o = expected_cells.size();
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for depth_pixel_to_grid_cell: directed corner pixels at reset
// settings, then phases of random pixels under several camera and grid
// settings, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb import dpg_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 12;
  localparam int PHASE_PIXELS   = 135;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pixel_t                in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cell_t                 out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;

  int   snd_idle = 0;
  int   rcv_stall = 0;
  int   rx_hold = 0;
  int   quiet_cycles = 0;
  cfg_t cur_cfg;

  always #5 clk = ~clk;

  depth_pixel_to_grid_cell uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  grid_cell_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper bits beyond each register's width carry junk
  task automatic set_config(input cfg_t c);
    cur_cfg = c;
    write_reg(CFG_CX, {8'($urandom), c.cx_q4});
    write_reg(CFG_CY, {8'($urandom), c.cy_q4});
    write_reg(CFG_INV_FX, c.inv_fx_q24);
    write_reg(CFG_INV_FY, c.inv_fy_q24);
    write_reg(CFG_CELL_SCALE, c.cell_scale_q16);
    write_reg(CFG_HALF_ROWS, {13'($urandom), c.half_rows});
    write_reg(CFG_HALF_COLS, {13'($urandom), c.half_cols});
    write_reg(CFG_FLOOR_LIMIT, {8'($urandom), c.floor_limit_q4});
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t phase_cfg(input int ph);
    cfg_t c;
    case (ph)
      1: begin
        c = '{16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              11'd2047, 11'd2047, 16'h8000};
      end
      2: begin
        // zero cell scale: every nonzero depth sits at the near edge
        c = '{16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 11'd1, 11'd1, 16'h8000};
      end
      3: begin
        // zero half sizes: nothing can land in the map
        c = '{16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom_range(20000, 100)), 11'd0, 11'd0, 16'h7FFF};
      end
      default: begin
        c.cx_q4 = 16'($urandom);
        c.cy_q4 = 16'($urandom);
        c.inv_fx_q24 = 24'($urandom_range(1 << 18, 1 << 12));
        c.inv_fy_q24 = 24'($urandom_range(1 << 18, 1 << 12));
        c.cell_scale_q16 = 24'($urandom_range(20000, 100));
        c.half_rows = 11'($urandom_range(2047, 1));
        c.half_cols = 11'($urandom_range(2047, 1));
        c.floor_limit_q4 = 16'(-int'($urandom_range(8000)));
        if ($urandom_range(3) == 0) begin
          c.inv_fx_q24 = 24'($urandom);
          c.cell_scale_q16 = 24'($urandom);
          c.floor_limit_q4 = 16'($urandom);
        end
      end
    endcase
    return c;
  endfunction

  function automatic int near(input int centre, input int span);
    int lo, hi;
    lo = (centre > span) ? centre - span : 0;
    hi = (centre + span < 4095) ? centre + span : 4095;
    return $urandom_range(hi, lo);
  endfunction

  // mostly pixels around the principal point at depths up to just beyond the far edge
  function automatic pixel_t random_pixel();
    pixel_t p;
    longint dlim;
    if ($urandom_range(99) < 25) begin
      p.pixel_col = PIXEL_BITS'($urandom);
      p.pixel_row = PIXEL_BITS'($urandom);
      p.depth_raw = DEPTH_W'($urandom);
    end else begin
      p.pixel_col = PIXEL_BITS'(near(int'(cur_cfg.cx_q4 >> 4), 32 << $urandom_range(6)));
      p.pixel_row = PIXEL_BITS'(near(int'(cur_cfg.cy_q4 >> 4), 32 << $urandom_range(6)));
      if (cur_cfg.cell_scale_q16 == 0) begin
        dlim = 65535;
      end else begin
        dlim = ((longint'(cur_cfg.half_cols) << 16) / cur_cfg.cell_scale_q16) * 9 / 8 + 1;
      end
      if (dlim > 65535) begin
        dlim = 65535;
      end
      p.depth_raw = DEPTH_W'($urandom_range(int'(dlim)));
    end
    return p;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel('{12'd320, 12'd240, 16'd0});
    send_pixel('{12'd0, 12'd0, 16'd1});
    send_pixel('{12'd4095, 12'd4095, 16'd65535});
    send_pixel('{12'd320, 12'd240, 16'd1000});
    send_pixel('{12'd0, 12'd240, 16'd3000});
    send_pixel('{12'd639, 12'd240, 16'd3000});
    send_pixel('{12'd320, 12'd0, 16'd4000});
    send_pixel('{12'd320, 12'd479, 16'd4000});
    send_pixel('{12'd320, 12'd240, 16'd4998});
    send_pixel('{12'd320, 12'd240, 16'd4999});
    send_pixel('{12'd4095, 12'd240, 16'd2000});
    send_pixel('{12'd0, 12'd4095, 16'd65535});
    send_pixel('{12'd4095, 12'd0, 16'd1});
    send_pixel('{12'd2048, 12'd2048, 16'd32768});
    send_pixel('{12'd1365, 12'd2730, 16'd21845});
    send_pixel('{12'd2730, 12'd1365, 16'd43690});
    send_pixel('{12'd100, 12'd400, 16'd2500});

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      set_config(phase_cfg(ph));
      case (ph % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 46; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 46; end
        default: begin snd_idle = 12; rcv_stall = 12; end
      endcase
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
      if (ph == 4) begin
        rx_hold = 300;
        repeat (60) send_pixel(random_pixel());
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
